>>> rtl/xymu_pkg.sv
package xymu_pkg;

	// field widths
	localparam int ANGLE_W    = 16;
	localparam int SITE_W     = 8;
	localparam int RAND_W     = 16;
	localparam int BETA_W     = 16;
	localparam int AMP_W      = 16;
	localparam int COUP_W     = 15;
	localparam int DE_W       = 20;
	localparam int COS_W      = 16;
	localparam int SUM_W      = 19;
	localparam int X_W        = 35;
	localparam int WEIGHT_W   = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int LATTICE_SIDE_DEF = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BETA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUP = 2'd2;

	// register reset values
	localparam logic [BETA_W-1:0] BETA_RST = 16'd256;
	localparam logic [AMP_W-1:0]  AMP_RST  = 16'd10430;
	localparam logic [COUP_W-1:0] COUP_RST = 15'd4096;

	// item kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_TRIAL = 1'b1;

	// fixed point constants
	localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
	localparam logic [28:0] INV_E_Q30  = 29'd395007543;
	localparam logic [30:0] Q30_ONE    = 31'd1073741824;

endpackage

>>> rtl/xymu_req_if.sv
interface xymu_req_if;
	import xymu_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [SITE_W-1:0]   site;
	logic [ANGLE_W-1:0]  load_angle;
	logic [RAND_W-1:0]   step_rand;
	logic [RAND_W-1:0]   accept_rand;

	modport source (output valid, req_type, site, load_angle, step_rand, accept_rand,
		input ready);
	modport sink (input valid, req_type, site, load_angle, step_rand, accept_rand,
		output ready);
endinterface

>>> rtl/xymu_rsp_if.sv
interface xymu_rsp_if;
	import xymu_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic [ANGLE_W-1:0]     site_angle;
	logic signed [DE_W-1:0] delta_energy;

	modport source (output valid, accepted, site_angle, delta_energy, input ready);
	modport sink (input valid, accepted, site_angle, delta_energy, output ready);
endinterface

>>> rtl/xymu_cfg_if.sv
interface xymu_cfg_if;
	import xymu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/xymu_mem.sv
module xymu_mem #(
	parameter int LATTICE_SIDE = xymu_pkg::LATTICE_SIDE_DEF,
	localparam int DEPTH = LATTICE_SIDE * LATTICE_SIDE,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [xymu_pkg::ANGLE_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [xymu_pkg::ANGLE_W-1:0] wr_data
);
	import xymu_pkg::*;

	logic [ANGLE_W-1:0] mem_q [DEPTH];
	logic [ANGLE_W-1:0] rd_data_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> rtl/xymu_cos.sv
module xymu_cos (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [xymu_pkg::ANGLE_W-1:0]     angle,
	output logic                             done,
	output logic signed [xymu_pkg::COS_W-1:0] cos_val
);
	import xymu_pkg::*;

	typedef enum logic [2:0] {C_IDLE, C_T, C_T2, C_MUL, C_DIV, C_FIX, C_OUT} cos_state_t;

	cos_state_t  state_q;
	logic [14:0] arg_q;
	logic        neg_q;
	logic [30:0] t_q;
	logic [31:0] t2_q;
	logic [30:0] p_q;
	logic [31:0] prod_q;
	logic [31:0] q0_q;
	logic [2:0]  k_q;

	// series divisors 90, 56, 30, 12, 2
	function automatic logic [6:0] div_k(input logic [2:0] idx);
		logic [6:0] k;
		unique case (idx)
			3'd0:    k = 7'd90;
			3'd1:    k = 7'd56;
			3'd2:    k = 7'd30;
			3'd3:    k = 7'd12;
			default: k = 7'd2;
		endcase
		return k;
	endfunction

	// floor((2^35 - 1) / k)
	function automatic logic [31:0] div_recip(input logic [2:0] idx);
		logic [31:0] r;
		unique case (idx)
			3'd0:    r = 32'd381774870;
			3'd1:    r = 32'd613566756;
			3'd2:    r = 32'd1145324612;
			3'd3:    r = 32'd2863311530;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	logic [1:0]  quad;
	logic [47:0] t_prod;
	logic [61:0] t2_prod;
	logic [62:0] p_prod;
	logic [63:0] recip_prod;
	logic [39:0] qk;
	logic [39:0] rem;
	logic [31:0] q_fix;
	logic [33:0] p_next;
	logic [30:0] c_round;

	assign quad       = angle[15:14];
	assign t_prod     = 48'(arg_q) * 48'(TWO_PI_Q30);
	assign t2_prod    = 62'(t_q) * 62'(t_q);
	assign p_prod     = 63'(t2_q) * 63'(p_q);
	assign recip_prod = 64'(prod_q) * 64'(div_recip(k_q));
	assign qk         = 40'(q0_q) * 40'(div_k(k_q));
	assign rem        = 40'(prod_q) - qk;
	assign q_fix      = q0_q + 32'((rem >= 40'(div_k(k_q))) ? 1 : 0);
	assign p_next     = 34'(Q30_ONE) - 34'(q_fix);
	assign c_round    = p_q + 31'd32768;

	// quarter-wave series, one multiply per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			unique case (state_q)
				C_IDLE: if (start) state_q <= C_T;
				C_T:    state_q <= C_T2;
				C_T2:   state_q <= C_MUL;
				C_MUL:  state_q <= C_DIV;
				C_DIV:  state_q <= C_FIX;
				C_FIX:  state_q <= (k_q == 3'd4) ? C_OUT : C_MUL;
				C_OUT:  state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (quad == 2'd0 || quad == 2'd2) begin
					arg_q <= {1'b0, angle[13:0]};
				end else begin
					arg_q <= 15'd16384 - {1'b0, angle[13:0]};
				end
				neg_q <= (quad == 2'd1 || quad == 2'd2);
			end
			C_T: t_q <= t_prod[46:16];
			C_T2: begin
				t2_q <= t2_prod[61:30];
				p_q  <= Q30_ONE;
				k_q  <= 3'd0;
			end
			C_MUL: prod_q <= p_prod[61:30];
			C_DIV: begin
				if (k_q == 3'd4) begin
					q0_q <= {1'b0, prod_q[31:1]};
				end else begin
					q0_q <= {3'b0, recip_prod[63:35]};
				end
			end
			C_FIX: begin
				p_q <= p_next[33] ? 31'd0 : p_next[30:0];
				k_q <= k_q + 3'd1;
			end
			default: ;
		endcase
	end

	assign done    = (state_q == C_OUT);
	assign cos_val = neg_q ? -$signed({1'b0, c_round[30:16]}) : $signed({1'b0, c_round[30:16]});
endmodule

>>> rtl/xymu_exp.sv
module xymu_exp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [xymu_pkg::X_W-1:0]          x,
	output logic                              done,
	output logic [xymu_pkg::WEIGHT_W-1:0]     weight
);
	import xymu_pkg::*;

	typedef enum logic [2:0] {E_IDLE, E_MUL, E_DIV, E_FIX, E_POW, E_OUT} exp_state_t;

	exp_state_t  state_q;
	logic        zero_q;
	logic [3:0]  n_q;
	logic [29:0] f_q;
	logic [30:0] p_q;
	logic [29:0] prod_q;
	logic [29:0] q0_q;
	logic [3:0]  k_q;

	// floor((2^32 - 1) / k) for k = 1..10
	function automatic logic [31:0] div_recip(input logic [3:0] k);
		logic [31:0] r;
		unique case (k)
			4'd1:    r = 32'd4294967295;
			4'd2:    r = 32'd2147483647;
			4'd3:    r = 32'd1431655765;
			4'd4:    r = 32'd1073741823;
			4'd5:    r = 32'd858993459;
			4'd6:    r = 32'd715827882;
			4'd7:    r = 32'd613566756;
			4'd8:    r = 32'd536870911;
			4'd9:    r = 32'd477218588;
			4'd10:   r = 32'd429496729;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	logic [60:0] fp_prod;
	logic [61:0] recip_prod;
	logic [33:0] qk;
	logic [33:0] rem;
	logic [29:0] q_fix;
	logic [59:0] pow_prod;
	logic [30:0] w_round;

	assign fp_prod    = 61'(f_q) * 61'(p_q);
	assign recip_prod = 62'(prod_q) * 62'(div_recip(k_q));
	assign qk         = 34'(q0_q) * 34'(k_q);
	assign rem        = 34'(prod_q) - qk;
	assign q_fix      = q0_q + 30'((rem >= 34'(k_q)) ? 1 : 0);
	assign pow_prod   = 60'(p_q) * 60'(INV_E_Q30) + 60'(1 << 29);
	assign w_round    = p_q + 31'd8192;

	// fractional series, then one factor 1/e per integer unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			unique case (state_q)
				E_IDLE: if (start) state_q <= (x[X_W-1:24] != '0) ? E_OUT : E_MUL;
				E_MUL:  state_q <= E_DIV;
				E_DIV:  state_q <= E_FIX;
				E_FIX:  state_q <= (k_q == 4'd1) ? E_POW : E_MUL;
				E_POW:  if (n_q == 4'd0) state_q <= E_OUT;
				E_OUT:  state_q <= E_IDLE;
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				zero_q <= (x[X_W-1:24] != '0);
				n_q    <= x[23:20];
				f_q    <= {x[19:0], 10'b0};
				p_q    <= Q30_ONE;
				k_q    <= 4'd10;
			end
			E_MUL: prod_q <= fp_prod[59:30];
			E_DIV: q0_q <= recip_prod[61:32];
			E_FIX: begin
				p_q <= Q30_ONE - 31'(q_fix);
				k_q <= k_q - 4'd1;
			end
			E_POW: begin
				if (n_q != 4'd0) begin
					p_q <= {1'b0, pow_prod[59:30]};
					n_q <= n_q - 4'd1;
				end
			end
			default: ;
		endcase
	end

	assign done   = (state_q == E_OUT);
	assign weight = zero_q ? '0 : w_round[30:14];
endmodule

>>> rtl/xy_model_metropolis_update.sv
// Metropolis update engine for a periodic square lattice of XY spins.
// Channels: req carries one item (load or trial) per valid/ready handshake,
// rsp returns exactly one result item per request, cfg writes the inverse
// temperature, step amplitude and coupling registers (ready is always high;
// write only while the engine is idle).
// A load passes through the row, write-back and finish states: it writes
// the site angle in write-back and registers its result on leaving finish.
// A trial reads the site and its four neighbours from the angle memory
// (one read per cycle), runs the iterative cosine unit eight times, and,
// for a positive energy change, the exp unit, which skips its series when
// the weight is zero; the result is registered on leaving the finish state,
// and the next item is taken in the idle state that follows.
// The cosine unit sets the rate. One item is worked on at a time.
// Reset clears the sequencer and the output valid flag and restores the
// register defaults; angle memory contents stay undefined until loaded.
// The result sits in an output register: if rsp stalls, the next item is
// still accepted and processed, and the engine waits only when a second
// result is ready while the first is still held.
module xy_model_metropolis_update #(
	parameter int LATTICE_SIDE = xymu_pkg::LATTICE_SIDE_DEF
) (
	input logic         clk,
	input logic         arst_n,
	xymu_cfg_if.sink    cfg,
	xymu_req_if.sink    req,
	xymu_rsp_if.source  rsp
);
	import xymu_pkg::*;

	localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
	localparam int AW         = $clog2(SITE_COUNT);
	localparam int ROW_RECIP  = (65536 + LATTICE_SIDE - 1) / LATTICE_SIDE;

	typedef enum logic [3:0] {
		S_IDLE, S_ROW, S_NBR, S_ROLD, S_RNB, S_COS_GO, S_COS_WAIT,
		S_DE, S_DEC, S_EXP_GO, S_EXP_WAIT, S_WB, S_FIN
	} seq_state_t;

	seq_state_t state_q;

	// registers
	logic [BETA_W-1:0] beta_q;
	logic [AMP_W-1:0]  amp_q;
	logic [COUP_W-1:0] coup_q;

	// item and working registers
	logic                   req_type_q;
	logic [SITE_W-1:0]      site_q;
	logic [ANGLE_W-1:0]     load_q;
	logic [RAND_W-1:0]      srand_q;
	logic [RAND_W-1:0]      arand_q;
	logic [SITE_W-1:0]      row_q;
	logic                   in_range_q;
	logic [ANGLE_W-1:0]     stp_q;
	logic [AW-1:0]          nb_q [4];
	logic [ANGLE_W-1:0]     na_q [4];
	logic [ANGLE_W-1:0]     old_q;
	logic [ANGLE_W-1:0]     nw_q;
	logic [1:0]             j_q;
	logic [2:0]             e_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [DE_W-1:0] de_q;
	logic [X_W-1:0]         x_q;
	logic                   acc_q;

	// result register
	logic                   rsp_valid_q;
	logic                   rsp_acc_q;
	logic [ANGLE_W-1:0]     rsp_angle_q;
	logic signed [DE_W-1:0] rsp_de_q;

	// memory and units
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [ANGLE_W-1:0]      rd_data;
	logic                    wr_en;
	logic                    cos_start;
	logic [ANGLE_W-1:0]      cos_angle;
	logic                    cos_done;
	logic signed [COS_W-1:0] cos_val;
	logic                    exp_start;
	logic                    exp_done;
	logic [WEIGHT_W-1:0]     exp_weight;

	xymu_mem #(.LATTICE_SIDE(LATTICE_SIDE)) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (AW'(site_q)),
		.wr_data (nw_q)
	);

	xymu_cos u_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cos_start),
		.angle   (cos_angle),
		.done    (cos_done),
		.cos_val (cos_val)
	);

	xymu_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.x      (x_q),
		.done   (exp_done),
		.weight (exp_weight)
	);

	// site decode and proposed step
	logic [24:0]             row_prod;
	logic                    in_range;
	logic signed [16:0]      sr_c;
	logic signed [33:0]      stp_prod;
	logic [16:0]             col;
	logic [17:0]             s18;
	logic [17:0]             side18;
	logic [17:0]             cnt18;
	logic [17:0]             nb_right, nb_left, nb_down, nb_up;
	logic signed [34:0]      de_prod;
	logic signed [SUM_W-1:0] cos_ext;
	logic [X_W-1:0]          x_prod;

	assign row_prod = 25'(site_q) * 25'(ROW_RECIP);
	assign in_range = (17'(site_q) < 17'(SITE_COUNT));
	assign sr_c     = $signed({1'b0, srand_q}) - 17'sd32768;
	assign stp_prod = $signed({1'b0, amp_q}) * sr_c + 34'sd32768;

	assign s18    = 18'(site_q);
	assign side18 = 18'(LATTICE_SIDE);
	assign cnt18  = 18'(SITE_COUNT);
	assign col    = 17'(site_q) - 17'(row_q) * 17'(LATTICE_SIDE);

	// periodic neighbours: right, left, down, up
	assign nb_right = (18'(col) == side18 - 18'd1) ? s18 + 18'd1 - side18 : s18 + 18'd1;
	assign nb_left  = (col == 17'd0) ? s18 + side18 - 18'd1 : s18 - 18'd1;
	assign nb_down  = (s18 + side18 >= cnt18) ? s18 + side18 - cnt18 : s18 + side18;
	assign nb_up    = (s18 < side18) ? s18 + cnt18 - side18 : s18 - side18;

	assign de_prod = $signed({1'b0, coup_q}) * sum_q + 35'sd8192;
	assign cos_ext = SUM_W'(cos_val);
	assign x_prod  = X_W'(beta_q) * X_W'(de_q[DE_W-2:0]);

	// memory port use per step
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(site_q);
		unique case (state_q)
			S_NBR: rd_en = 1'b1;
			S_ROLD: begin
				rd_en   = 1'b1;
				rd_addr = nb_q[0];
			end
			S_RNB: begin
				rd_en   = 1'b1;
				rd_addr = nb_q[2'(j_q + 2'd1)];
			end
			default: ;
		endcase
	end

	assign wr_en     = (state_q == S_WB) && acc_q;
	assign cos_start = (state_q == S_COS_GO);
	assign cos_angle = (e_q[0] ? nw_q : old_q) - na_q[e_q[2:1]];
	assign exp_start = (state_q == S_EXP_GO);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// sequencer, registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			beta_q      <= BETA_RST;
			amp_q       <= AMP_RST;
			coup_q      <= COUP_RST;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.reg_index)
					CFG_BETA: beta_q <= cfg.wdata;
					CFG_AMP:  amp_q  <= cfg.wdata;
					CFG_COUP: coup_q <= cfg.wdata[COUP_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (req.valid) state_q <= S_ROW;
				S_ROW: begin
					if (!in_range) begin
						state_q <= S_FIN;
					end else if (req_type_q == REQ_LOAD) begin
						state_q <= S_WB;
					end else begin
						state_q <= S_NBR;
					end
				end
				S_NBR:  state_q <= S_ROLD;
				S_ROLD: state_q <= S_RNB;
				S_RNB:  if (j_q == 2'd3) state_q <= S_COS_GO;
				S_COS_GO: state_q <= S_COS_WAIT;
				S_COS_WAIT: begin
					if (cos_done) begin
						state_q <= (e_q == 3'd7) ? S_DE : S_COS_GO;
					end
				end
				S_DE:  state_q <= S_DEC;
				S_DEC: state_q <= (de_q <= 0) ? S_WB : S_EXP_GO;
				S_EXP_GO: state_q <= S_EXP_WAIT;
				S_EXP_WAIT: if (exp_done) state_q <= S_WB;
				S_WB: state_q <= S_FIN;
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_acc_q   <= acc_q;
						rsp_angle_q <= acc_q ? nw_q : old_q;
						rsp_de_q    <= de_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_type_q <= req.req_type;
				site_q     <= req.site;
				load_q     <= req.load_angle;
				srand_q    <= req.step_rand;
				arand_q    <= req.accept_rand;
			end
			S_ROW: begin
				row_q      <= row_prod[23:16];
				in_range_q <= in_range;
				stp_q      <= stp_prod[31:16];
				de_q       <= '0;
				old_q      <= '0;
				if (!in_range) begin
					acc_q <= 1'b0;
					nw_q  <= '0;
				end else begin
					acc_q <= (req_type_q == REQ_LOAD);
					nw_q  <= load_q;
				end
			end
			S_NBR: begin
				nb_q[0] <= AW'(nb_right);
				nb_q[1] <= AW'(nb_left);
				nb_q[2] <= AW'(nb_down);
				nb_q[3] <= AW'(nb_up);
			end
			S_ROLD: begin
				old_q <= rd_data;
				nw_q  <= rd_data + stp_q;
				j_q   <= 2'd0;
			end
			S_RNB: begin
				na_q[j_q] <= rd_data;
				j_q       <= j_q + 2'd1;
				e_q       <= 3'd0;
				sum_q     <= '0;
			end
			S_COS_WAIT: begin
				if (cos_done) begin
					sum_q <= e_q[0] ? sum_q - cos_ext : sum_q + cos_ext;
					e_q   <= e_q + 3'd1;
				end
			end
			S_DE: de_q <= de_prod[33:14];
			S_DEC: begin
				x_q <= x_prod;
				if (de_q <= 0) begin
					acc_q <= 1'b1;
				end
			end
			S_EXP_WAIT: begin
				if (exp_done) begin
					acc_q <= (WEIGHT_W'(arand_q) < exp_weight);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.accepted     = rsp_acc_q && in_range_q | rsp_acc_q;
	assign rsp.site_angle   = rsp_angle_q;
	assign rsp.delta_energy = rsp_de_q;
endmodule

>>> sim/xy_model_metropolis_update_tb.sv
module xy_model_metropolis_update_tb;
	import xymu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE        = LATTICE_SIDE_DEF;
	localparam int SITES       = SIDE * SIDE;
	localparam int SETTLE      = 300;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic               req_type;
		logic [SITE_W-1:0]  site;
		logic [ANGLE_W-1:0] load_angle;
		logic [RAND_W-1:0]  step_rand;
		logic [RAND_W-1:0]  accept_rand;
	} spin_item_t;

	typedef struct packed {
		logic               accepted;
		logic [ANGLE_W-1:0] site_angle;
		logic [DE_W-1:0]    delta_energy;
	} spin_result_t;

	logic clk;
	logic arst_n;

	xymu_cfg_if cfg ();
	xymu_req_if req ();
	xymu_rsp_if rsp ();

	xy_model_metropolis_update uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// predictor state
	logic [ANGLE_W-1:0] lattice_angle [SITES];
	logic [BETA_W-1:0]  beta_q88;
	logic [AMP_W-1:0]   jump_width;
	logic [COUP_W-1:0]  coupling_q312;

	spin_result_t expected_results[$];

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int items_sent;
	int results_seen;
	int trials_sent;
	int rejects_seen;
	int quiet_cycles;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// cosine of r/65536 turns for a quarter wave, Q2.14
	function automatic longint quarter_wave_cos(input longint unsigned r);
		longint unsigned t;
		longint unsigned t2;
		longint unsigned prod;
		longint p;
		longint dens [5];
		dens = '{90, 56, 30, 12, 2};
		t = (r * 64'(TWO_PI_Q30)) >> 16;
		t2 = (t * t) >> 30;
		p = longint'(Q30_ONE);
		for (int k = 0; k < 5; k++) begin
			prod = (t2 * longint'(p)) >> 30;
			p = longint'(Q30_ONE) - longint'(prod) / dens[k];
			if (p < 0)
				p = 0;
		end
		return (p + 32768) >> 16;
	endfunction

	function automatic longint turn_cosine(input logic [ANGLE_W-1:0] a);
		longint unsigned r;
		r = a[13:0];
		case (a[15:14])
			2'd0: return quarter_wave_cos(r);
			2'd1: return -quarter_wave_cos(16384 - r);
			2'd2: return -quarter_wave_cos(r);
			default: return quarter_wave_cos(16384 - r);
		endcase
	endfunction

	// exp(-x) in Q1.16 for x in Q16.20
	function automatic longint unsigned boltzmann_weight(input longint unsigned x);
		longint unsigned n;
		longint unsigned f;
		longint unsigned p;
		if (x >= (64'd16 << 20))
			return 0;
		n = x >> 20;
		f = (x & 64'hFFFFF) << 10;
		p = 64'(Q30_ONE);
		for (int k = 10; k >= 1; k--)
			p = 64'(Q30_ONE) - ((f * p) >> 30) / longint'(k);
		for (longint unsigned i = 0; i < n; i++)
			p = (p * 64'(INV_E_Q30) + (64'd1 << 29)) >> 30;
		return (p + 8192) >> 14;
	endfunction

	// works out the result of one item and updates the lattice copy
	function automatic spin_result_t predict_spin(input spin_item_t it);
		spin_result_t res;
		int s;
		int col;
		int nb [4];
		logic [ANGLE_W-1:0] old_a;
		logic [ANGLE_W-1:0] new_a;
		longint stp;
		longint sum;
		longint de;
		logic acc;
		s = it.site;
		res = '0;
		if (s >= SITES)
			return res;
		if (it.req_type == REQ_LOAD) begin
			lattice_angle[s] = it.load_angle;
			res.accepted = 1'b1;
			res.site_angle = it.load_angle;
			return res;
		end
		col = s % SIDE;
		nb[0] = (col == SIDE - 1) ? s + 1 - SIDE : s + 1;
		nb[1] = (col == 0) ? s + SIDE - 1 : s - 1;
		nb[2] = (s + SIDE >= SITES) ? s + SIDE - SITES : s + SIDE;
		nb[3] = (s < SIDE) ? s + SITES - SIDE : s - SIDE;
		stp = longint'(jump_width) * (longint'(it.step_rand) - 32768);
		stp = (stp + 32768) >>> 16;
		old_a = lattice_angle[s];
		new_a = ANGLE_W'(longint'(old_a) + stp);
		sum = 0;
		for (int j = 0; j < 4; j++) begin
			sum += turn_cosine(old_a - lattice_angle[nb[j]]);
			sum -= turn_cosine(new_a - lattice_angle[nb[j]]);
		end
		de = (longint'(coupling_q312) * sum + 8192) >>> 14;
		if (de <= 0)
			acc = 1'b1;
		else
			acc = longint'(it.accept_rand)
				< longint'(boltzmann_weight(64'(beta_q88) * 64'(de)));
		if (acc)
			lattice_angle[s] = new_a;
		res.accepted = acc;
		res.site_angle = lattice_angle[s];
		res.delta_energy = DE_W'(de);
		return res;
	endfunction

	// sends one item, predicting its result on acceptance
	task automatic send_item(input spin_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.req_type    <= it.req_type;
		req.site        <= it.site;
		req.load_angle  <= it.load_angle;
		req.step_rand   <= it.step_rand;
		req.accept_rand <= it.accept_rand;
		@(negedge clk);
		while (!req.ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		expected_results.push_back(predict_spin(it));
		items_sent++;
		if (it.req_type == REQ_TRIAL)
			trials_sent++;
	endtask

	task automatic send_load(input int s, input logic [ANGLE_W-1:0] a);
		spin_item_t it;
		it = '{REQ_LOAD, SITE_W'(s), a, RAND_W'($urandom), RAND_W'($urandom)};
		send_item(it);
	endtask

	task automatic send_trial(input int s, input logic [RAND_W-1:0] sr,
			input logic [RAND_W-1:0] ar);
		spin_item_t it;
		it = '{REQ_TRIAL, SITE_W'(s), ANGLE_W'($urandom), sr, ar};
		send_item(it);
	endtask

	// drains the engine, then writes one register
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		req.valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		cfg.valid     <= 1'b1;
		cfg.reg_index <= idx;
		cfg.wdata     <= val;
		@(negedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_BETA: beta_q88 = val;
			CFG_AMP:  jump_width = val;
			CFG_COUP: coupling_q312 = COUP_W'(val);
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [BETA_W-1:0] b, input logic [AMP_W-1:0] a,
			input logic [COUP_W-1:0] c);
		write_register(CFG_BETA, b);
		write_register(CFG_AMP, a);
		write_register(CFG_COUP, 16'(c));
	endtask

	// every site gets a value, angle extremes included
	task automatic test_lattice_load();
		send_load(0, 16'h0000);
		send_load(1, 16'hFFFF);
		for (int s = 2; s < SITES; s++)
			send_load(s, ANGLE_W'($urandom));
	endtask

	// corner sites, step and accept extremes, zero step
	task automatic test_directed_trials();
		int corners [4];
		corners = '{0, SIDE - 1, SITES - SIDE, SITES - 1};
		foreach (corners[i]) begin
			send_trial(corners[i], 16'h0000, 16'hFFFF);
			send_trial(corners[i], 16'hFFFF, 16'h0000);
			send_trial(corners[i], 16'h8000, 16'hFFFF);
		end
		send_load(17, 16'h4000);
		send_trial(17, 16'h0000, 16'h0000);
		send_trial(17, 16'hFFFF, 16'hFFFF);
	endtask

	// mostly trials, some reloads, random content
	task automatic test_random_sweep(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15)
				send_load($urandom_range(SITES - 1), ANGLE_W'($urandom));
			else
				send_trial($urandom_range(SITES - 1), RAND_W'($urandom),
					RAND_W'($urandom));
		end
	endtask

	// receiver stalls
	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

	// result checking
	always @(negedge clk) begin
		spin_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: accepted=%0b angle=%0d dE=%0d", $time,
					rsp.accepted, rsp.site_angle, rsp.delta_energy);
			end else begin
				exp_r = expected_results.pop_front();
				if (!exp_r.accepted)
					rejects_seen++;
				if (rsp.accepted !== exp_r.accepted) begin
					errors++;
					$display("%0t: accepted expected %0b actual %0b", $time,
						exp_r.accepted, rsp.accepted);
				end
				if (rsp.site_angle !== exp_r.site_angle) begin
					errors++;
					$display("%0t: site_angle expected %0d actual %0d", $time,
						exp_r.site_angle, rsp.site_angle);
				end
				if (rsp.delta_energy !== exp_r.delta_energy) begin
					errors++;
					$display("%0t: delta_energy expected %0d actual %0d", $time,
						$signed(exp_r.delta_energy), rsp.delta_energy);
				end
			end
		end
	end

	// watchdog on handshake activity
	always @(negedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("xy_model_metropolis_update_tb: FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		trials_sent = 0;
		rejects_seen = 0;
		quiet_cycles = 0;
		send_idle_pct = 30;
		recv_stall_pct = 46;
		beta_q88 = BETA_RST;
		jump_width = AMP_RST;
		coupling_q312 = COUP_RST;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.req_type <= REQ_LOAD;
		req.site <= '0;
		req.load_angle <= '0;
		req.step_rand <= '0;
		req.accept_rand <= '0;
		cfg.valid <= 1'b0;
		cfg.reg_index <= CFG_BETA;
		cfg.wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lattice_load();
		test_directed_trials();
		test_random_sweep(120);

		// hot and wide: everything accepted
		send_idle_pct = 46;
		recv_stall_pct = 30;
		write_all(16'h0000, 16'hFFFF, 15'h7FFF);
		test_random_sweep(120);

		// cold: large dE mostly rejected
		write_all(16'hFFFF, 16'h2000, 15'h7FFF);
		test_random_sweep(100);

		// no coupling, no step
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_all(16'h0100, 16'h0000, 15'h0000);
		test_directed_trials();

		// random settings
		for (int ph = 0; ph < 3; ph++) begin
			write_all(BETA_W'($urandom_range(16'h07FF)), AMP_W'($urandom),
				COUP_W'($urandom));
			test_random_sweep(60);
		end

		req.valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d items (%0d trials, %0d rejected) over %0d results,",
			items_sent, trials_sent, rejects_seen, results_seen);
		$display("with seven register settings and three idling patterns");
		if (errors == 0 && expected_results.size() == 0)
			$display("xy_model_metropolis_update_tb: PASS");
		else
			$display("xy_model_metropolis_update_tb: FAIL");
		$finish;
	end

endmodule
